>>> hdl/assert_macros.svh
// assertion macros used by the duart channel rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hdl/duart_pkg.sv
// types and constants for the duart receive channel register block
package duart_pkg;

  // operation carried by each input transfer
  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_HOST_BYTE = 2'd1,
    OP_REG_READ  = 2'd2,
    OP_REG_WRITE = 2'd3
  } op_t;

  // channel register map
  typedef enum logic [2:0] {
    REG_MR       = 3'd0,
    REG_SR_CSR   = 3'd1,
    REG_CR       = 3'd2,
    REG_RB_TB    = 3'd3,
    REG_IPCR_ACR = 3'd4,
    REG_ISR_IMR  = 3'd5,
    REG_CTR_UP   = 3'd6,
    REG_CTR_LO   = 3'd7
  } reg_addr_t;

  // command register upper nibble codes
  localparam logic [3:0] CR_CMD_RESET_MR_PTR = 4'h1;
  localparam logic [3:0] CR_CMD_RESET_RX     = 4'h2;

  // command register enable / disable bits
  localparam int CR_RX_ENABLE  = 0;
  localparam int CR_RX_DISABLE = 1;
  localparam int CR_TX_ENABLE  = 2;
  localparam int CR_TX_DISABLE = 3;

  // status and interrupt status bits
  localparam logic [7:0] SR_TX_RDY_EMT = 8'h0C;
  localparam logic [7:0] SR_RX_RDY     = 8'h01;
  localparam logic [7:0] ISR_TX_RDY    = 8'h01;
  localparam logic [7:0] ISR_RX_RDY    = 8'h02;

  localparam logic [15:0] CYCLES_PER_BYTE_RST = 16'd6720;

endpackage

>>> hdl/duart_receive_channel_regs.sv
// one duart channel behind eight byte registers with a paced host receive queue
//
// Input channel (in_): one transfer per operation, selected by in_tuser:
// a time tick, a byte from the host, a register read or a register write.
// Output channel (out_): exactly one result transfer per input transfer, in
// order, carrying read data, a transmit byte and the interrupt/overflow flags.
// Host bytes wait in a QUEUE_DEPTH entry queue held in a memory; a tick
// counts the pacing counter down and, once it has run out, moves the oldest
// queued byte into the receive holding register if the receiver is enabled
// and empty. cfg_wr_en/cfg_wr_data set the pacing count (cycles per byte).
// The result passes through the input register and then the result
// register. Throughput: one transfer per cycle while out_tready is high;
// the queue head is prefetched into a register so a load need not wait
// for a memory read. Reset (rst_n low at a clock edge) empties the
// queue, clears all channel registers and sets the pacing count to 6720.
// When the result side stalls, the result register and the input
// register both fill, then in_tready drops until out_tready returns;
// nothing is lost or repeated.
`include "assert_macros.svh"

module duart_receive_channel_regs
  import duart_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: cycles per received byte
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: delta_cycles[15:0], reg_addr[18:16], write_data[26:19],
  // host_byte[34:27], zero pad[39:35]
  input  logic [39:0] in_tdata,
  // in_tuser: operation[1:0]
  input  logic [1:0]  in_tuser,
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: read_data[7:0], tx_byte[15:8], rx_interrupt[16],
  // queue_overflow[17], zero pad[23:18]
  output logic [23:0] out_tdata,
  // out_tuser: read_valid[0], tx_valid[1]
  output logic [1:0]  out_tuser
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  // configuration
  logic [15:0] cpb_r;

  // input register
  logic        in_valid_r;
  op_t         op_r;
  logic [15:0] delta_r;
  reg_addr_t   addr_r;
  logic [7:0]  wdata_r;
  logic [7:0]  hbyte_r;

  // result register
  logic        out_valid_r;
  logic [23:0] out_tdata_r;
  logic [1:0]  out_tuser_r;

  // channel state
  logic [7:0]  mode0_r, mode0_nxt;
  logic [7:0]  mode1_r, mode1_nxt;
  logic        mode_ptr_r, mode_ptr_nxt;
  logic [7:0]  csr_r, csr_nxt;
  logic [7:0]  acr_r, acr_nxt;
  logic [7:0]  imr_r, imr_nxt;
  logic [7:0]  rx_hold_r, rx_hold_nxt;
  logic        rx_full_r, rx_full_nxt;
  logic        rx_en_r, rx_en_nxt;
  logic        tx_en_r, tx_en_nxt;
  logic [15:0] pace_r, pace_nxt;

  // queue
  logic [7:0]       queue_mem [QUEUE_DEPTH];
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       head_data_r;
  logic             q_wr_en;

  // result fields
  logic        read_valid_nxt;
  logic [7:0]  read_data_nxt;
  logic        tx_valid_nxt;
  logic [7:0]  tx_byte_nxt;
  logic        irq_nxt;
  logic        ovf_nxt;

  logic        advance;
  logic        q_empty;
  logic        q_full;

  // handshake: input register moves on when the result register is free
  assign advance    = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready  = ~in_valid_r | advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign q_empty = (count_r == '0);
  assign q_full  = (count_r == FULL_CNT);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpb_r <= CYCLES_PER_BYTE_RST;
    end else if (cfg_wr_en) begin
      cpb_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op_r    <= op_t'(in_tuser);
      delta_r <= in_tdata[15:0];
      addr_r  <= reg_addr_t'(in_tdata[18:16]);
      wdata_r <= in_tdata[26:19];
      hbyte_r <= in_tdata[34:27];
    end
  end

  // operation decode and next state
  always_comb begin
    mode0_nxt      = mode0_r;
    mode1_nxt      = mode1_r;
    mode_ptr_nxt   = mode_ptr_r;
    csr_nxt        = csr_r;
    acr_nxt        = acr_r;
    imr_nxt        = imr_r;
    rx_hold_nxt    = rx_hold_r;
    rx_full_nxt    = rx_full_r;
    rx_en_nxt      = rx_en_r;
    tx_en_nxt      = tx_en_r;
    pace_nxt       = pace_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    q_wr_en        = 1'b0;
    read_valid_nxt = 1'b0;
    read_data_nxt  = '0;
    tx_valid_nxt   = 1'b0;
    tx_byte_nxt    = '0;
    irq_nxt        = 1'b0;
    ovf_nxt        = 1'b0;

    if (advance) begin
      unique case (op_r)
        OP_TICK: begin
          if (pace_r > delta_r) begin
            pace_nxt = pace_r - delta_r;
          end else if (!rx_full_r && rx_en_r && !q_empty) begin
            // pacing ran out: load the oldest queued byte
            rx_hold_nxt = head_data_r;
            head_nxt    = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
            count_nxt   = count_r - 1'b1;
            rx_full_nxt = 1'b1;
            pace_nxt    = cpb_r;
            irq_nxt     = 1'b1;
          end else begin
            pace_nxt = '0;
          end
        end
        OP_HOST_BYTE: begin
          if (q_full) begin
            ovf_nxt = 1'b1;
          end else begin
            q_wr_en   = 1'b1;
            tail_nxt  = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_REG_READ: begin
          read_valid_nxt = 1'b1;
          unique case (addr_r)
            REG_MR:      read_data_nxt = mode_ptr_r ? mode1_r : mode0_r;
            REG_SR_CSR:  read_data_nxt = SR_TX_RDY_EMT | (rx_full_r ? SR_RX_RDY : 8'h00);
            REG_RB_TB: begin
              read_data_nxt = rx_hold_r;
              rx_full_nxt   = 1'b0;
            end
            REG_ISR_IMR: read_data_nxt = ISR_TX_RDY | (rx_full_r ? ISR_RX_RDY : 8'h00);
            REG_CR, REG_IPCR_ACR, REG_CTR_UP, REG_CTR_LO: read_data_nxt = '0;
          endcase
        end
        OP_REG_WRITE: begin
          unique case (addr_r)
            REG_MR: begin
              if (mode_ptr_r) begin
                mode1_nxt = wdata_r;
              end else begin
                mode0_nxt = wdata_r;
              end
              mode_ptr_nxt = 1'b1;
            end
            REG_SR_CSR:   csr_nxt = wdata_r;
            REG_CR: begin
              // command nibble, then enable/disable bits (disable wins)
              if (wdata_r[7:4] == CR_CMD_RESET_MR_PTR) begin
                mode_ptr_nxt = 1'b0;
              end else if (wdata_r[7:4] == CR_CMD_RESET_RX) begin
                rx_full_nxt = 1'b0;
              end
              if (wdata_r[CR_RX_ENABLE])  rx_en_nxt = 1'b1;
              if (wdata_r[CR_RX_DISABLE]) rx_en_nxt = 1'b0;
              if (wdata_r[CR_TX_ENABLE])  tx_en_nxt = 1'b1;
              if (wdata_r[CR_TX_DISABLE]) tx_en_nxt = 1'b0;
            end
            REG_RB_TB: begin
              tx_valid_nxt = 1'b1;
              tx_byte_nxt  = wdata_r;
            end
            REG_IPCR_ACR: acr_nxt = wdata_r;
            REG_ISR_IMR:  imr_nxt = wdata_r;
            REG_CTR_UP, REG_CTR_LO: ;
          endcase
        end
      endcase
    end
  end

  // channel state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode0_r    <= '0;
      mode1_r    <= '0;
      mode_ptr_r <= 1'b0;
      csr_r      <= '0;
      acr_r      <= '0;
      imr_r      <= '0;
      rx_hold_r  <= '0;
      rx_full_r  <= 1'b0;
      rx_en_r    <= 1'b0;
      tx_en_r    <= 1'b0;
      pace_r     <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
    end else begin
      mode0_r    <= mode0_nxt;
      mode1_r    <= mode1_nxt;
      mode_ptr_r <= mode_ptr_nxt;
      csr_r      <= csr_nxt;
      acr_r      <= acr_nxt;
      imr_r      <= imr_nxt;
      rx_hold_r  <= rx_hold_nxt;
      rx_full_r  <= rx_full_nxt;
      rx_en_r    <= rx_en_nxt;
      tx_en_r    <= tx_en_nxt;
      pace_r     <= pace_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
    end
  end

  // queue memory with registered head prefetch, bypassed on a write to the new head
  always_ff @(posedge clk) begin
    if (q_wr_en) begin
      queue_mem[tail_r] <= hbyte_r;
    end
    if (q_wr_en && (tail_r == head_nxt)) begin
      head_data_r <= hbyte_r;
    end else begin
      head_data_r <= queue_mem[head_nxt];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tdata_r <= {6'b0, ovf_nxt, irq_nxt, tx_byte_nxt, read_data_nxt};
      out_tuser_r <= {tx_valid_nxt, read_valid_nxt};
    end
  end

  // checks
  `ASSERT_NEVER(a_count_in_range, count_r > FULL_CNT, "queue count above depth")
  `ASSERT_CLK(a_empty_ptrs_meet, (count_r == '0) |-> (head_r == tail_r),
              "empty queue with head and tail apart")
  `ASSERT_CLK(a_load_sets_full, (advance && irq_nxt) |=> rx_full_r,
              "receiver load did not set full")
  `ASSERT_CLK(a_load_restarts_pace, (advance && irq_nxt) |=> (pace_r == $past(cpb_r)),
              "pacing counter not restarted after load")

endmodule
